/* rtl/core/dtq_pkg.sv */
// dtq_pkg: shared types and constants for the deadline timer queue
// depends on nothing; used by dtq_ctrl, dtq_datapath and the top level
package dtq_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_W        = 48;
  localparam int ID_W          = 32;
  localparam int PER_W         = 32;
  localparam int THR_W         = 32;
  localparam int CNT_OUT_W     = 5;
  localparam logic [31:0] THR_RESET = 32'd1000;

  typedef enum logic [2:0] {
    OP_ARM_ABS    = 3'd0,
    OP_ARM_DELAY  = 3'd1,
    OP_ARM_PERIOD = 3'd2,
    OP_POLL       = 3'd3,
    OP_CANCEL_TSK = 3'd4,
    OP_CANCEL_REP = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_FIRED   = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_NONE    = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic latch;       // take the input item
    logic unknown;     // item has an opcode with no meaning
    logic scan_start;  // begin a sweep over all slots
    logic apply;       // arm or cancel on the sweep result
    logic rd_best;     // read the chosen slot
    logic fire;        // handle the chosen due slot
    logic push;        // send the held poll result, not last
    logic final_out;   // send the closing result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic is_poll;
    logic known;
    logic pend_v;
    logic out_free;
  } sts_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

/* rtl/core/dtq_ctrl.sv */
// dtq_ctrl: sequencer for the timer queue, one-hot state machine
// depends on dtq_pkg; drives dtq_datapath through cmd_t, reads sts_t
module dtq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  dtq_pkg::sts_t  sts,
  output dtq_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_APPLY = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_FIRE  = 7'b0010000,
    ST_PUSH  = 7'b0100000,
    ST_FINAL = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          state_nxt = ST_SCAN;
          cmd.scan_start = 1'b1;
        end
      end
      ST_SCAN: begin
        // the opcode is known only once latched, so an unknown one leaves here
        if (!sts.known) begin
          cmd.unknown = 1'b1;
          state_nxt   = ST_FINAL;
        end else if (sts.scan_done) begin
          if (!sts.is_poll) state_nxt = ST_APPLY;
          else if (!sts.found) state_nxt = ST_FINAL;
          else if (sts.pend_v) state_nxt = ST_PUSH;
          else state_nxt = ST_READ;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_FINAL;
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_best = 1'b1;
        state_nxt   = ST_FIRE;
      end
      ST_FIRE: begin
        cmd.fire       = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.final_out = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* rtl/core/dtq_datapath.sv */
// dtq_datapath: slot store, sweep comparator, counters and result register
// depends on dtq_pkg; commanded by dtq_ctrl
module dtq_datapath #(
  parameter int SLOTS = dtq_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dtq_pkg::cmd_t                 cmd,
  output dtq_pkg::sts_t                 sts,
  input  logic [2:0]                    in_opcode,
  input  logic [dtq_pkg::TIME_W-1:0]    in_now,
  input  logic [dtq_pkg::TIME_W-1:0]    in_time_value,
  input  logic [dtq_pkg::PER_W-1:0]     in_period,
  input  logic [dtq_pkg::ID_W-1:0]      in_task_id,
  input  logic [dtq_pkg::ID_W-1:0]      in_repeat_id,
  input  logic                          in_can_skip,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtq_pkg::THR_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [dtq_pkg::ID_W-1:0]      out_task,
  output logic                          out_ok,
  output logic [dtq_pkg::CNT_OUT_W-1:0] out_pending_count,
  output logic                          out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam int TW = dtq_pkg::TIME_W;

  // slot store
  logic [TW-1:0]                 mem_dl   [SLOTS];
  logic [dtq_pkg::PER_W-1:0]     mem_per  [SLOTS];
  logic [dtq_pkg::ID_W-1:0]      mem_task [SLOTS];
  logic [dtq_pkg::ID_W-1:0]      mem_rep  [SLOTS];
  logic                          mem_skip [SLOTS];
  logic [TW-1:0]                 rd_dl_r;
  logic [dtq_pkg::PER_W-1:0]     rd_per_r;
  logic [dtq_pkg::ID_W-1:0]      rd_task_r, rd_rep_r;
  logic                          rd_skip_r;
  logic [SLOTS-1:0]              valid_r, done_r;
  logic [CW-1:0]                 cnt_r;

  // latched item
  logic [2:0]                    op_r;
  logic [TW-1:0]                 now_r, tv_r;
  logic [dtq_pkg::PER_W-1:0]     per_r;
  logic [dtq_pkg::ID_W-1:0]      task_r, rep_r;
  logic                          skip_r;
  logic [dtq_pkg::THR_W-1:0]     thr_r;

  // sweep
  logic [IW-1:0]                 idx_r, stg_idx_r, best_r, rd_addr;
  logic                          iss_r, stg_v_r, have_r, sdone_r;
  logic [TW-1:0]                 best_dl_r;
  logic                          cand, better;

  // held poll result and command outcome
  logic                          pend_v_r, res_ok_r;
  logic [1:0]                    pend_kind_r;
  logic [dtq_pkg::ID_W-1:0]      pend_task_r;
  logic [CW-1:0]                 pend_cnt_r;

  logic                          is_poll, is_arm, known, out_free;
  logic [TW-1:0]                 arm_dl, late;
  logic                          drop, rearm;

  assign is_poll = (op_r == dtq_pkg::OP_POLL);
  assign is_arm  = (op_r == dtq_pkg::OP_ARM_ABS) || (op_r == dtq_pkg::OP_ARM_DELAY) ||
                   (op_r == dtq_pkg::OP_ARM_PERIOD);
  assign known   = is_arm || is_poll || (op_r == dtq_pkg::OP_CANCEL_TSK) ||
                   (op_r == dtq_pkg::OP_CANCEL_REP);
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= dtq_pkg::THR_RESET;
    else if (cfg_valid && cfg_ready) thr_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_opcode;
      now_r  <= in_now;
      tv_r   <= in_time_value;
      per_r  <= in_period;
      task_r <= in_task_id;
      rep_r  <= in_repeat_id;
      skip_r <= in_can_skip;
    end
  end

  // candidate test on the element leaving the read stage
  always_comb begin
    cand = 1'b0;
    unique case (op_r)
      dtq_pkg::OP_CANCEL_TSK: cand = valid_r[stg_idx_r] && (rd_task_r == task_r);
      dtq_pkg::OP_CANCEL_REP: cand = valid_r[stg_idx_r] && (rd_rep_r == rep_r);
      dtq_pkg::OP_POLL:       cand = valid_r[stg_idx_r] && !done_r[stg_idx_r] &&
                                     (rd_dl_r <= now_r);
      default:                cand = !valid_r[stg_idx_r];
    endcase
    // arming takes the first free slot, the rest keep the earliest deadline
    better = !have_r || (!is_arm && (rd_dl_r < best_dl_r));
  end

  assign rd_addr = iss_r ? idx_r : best_r;

  always_ff @(posedge clk) begin
    if (iss_r || cmd.rd_best) begin
      rd_dl_r   <= mem_dl[rd_addr];
      rd_per_r  <= mem_per[rd_addr];
      rd_task_r <= mem_task[rd_addr];
      rd_rep_r  <= mem_rep[rd_addr];
      rd_skip_r <= mem_skip[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r   <= 1'b0;
      stg_v_r <= 1'b0;
      sdone_r <= 1'b0;
      have_r  <= 1'b0;
    end else if (cmd.scan_start) begin
      idx_r   <= '0;
      iss_r   <= 1'b1;
      stg_v_r <= 1'b0;
      sdone_r <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      stg_v_r   <= iss_r;
      stg_idx_r <= idx_r;
      sdone_r   <= stg_v_r && (stg_idx_r == LAST_IDX);
      if (iss_r) begin
        if (idx_r == LAST_IDX) iss_r <= 1'b0;
        else                   idx_r <= idx_r + 1'b1;
      end
      if (stg_v_r && cand && better) begin
        have_r    <= 1'b1;
        best_r    <= stg_idx_r;
        best_dl_r <= rd_dl_r;
      end
    end
  end

  always_comb begin
    unique case (op_r)
      dtq_pkg::OP_ARM_DELAY:  arm_dl = dtq_pkg::sat_add(now_r, tv_r);
      dtq_pkg::OP_ARM_PERIOD: arm_dl = dtq_pkg::sat_add(now_r, TW'(per_r));
      default:                arm_dl = tv_r;
    endcase
  end

  assign late  = now_r - best_dl_r;
  assign drop  = rd_skip_r && (late > TW'(thr_r));
  assign rearm = (rd_per_r != '0) && (rd_rep_r != '0);

  // store writes
  always_ff @(posedge clk) begin
    if (cmd.apply && is_arm && have_r) begin
      mem_dl[best_r]   <= arm_dl;
      mem_per[best_r]  <= (op_r == dtq_pkg::OP_ARM_PERIOD) ? per_r : '0;
      mem_task[best_r] <= task_r;
      mem_rep[best_r]  <= (op_r == dtq_pkg::OP_ARM_PERIOD) ? rep_r : '0;
      mem_skip[best_r] <= skip_r;
    end else if (cmd.fire && !drop && rearm) begin
      mem_dl[best_r] <= dtq_pkg::sat_add(now_r, TW'(rd_per_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      res_ok_r <= 1'b0;
    end else begin
      if (cmd.latch) begin
        done_r   <= '0;
        pend_v_r <= 1'b0;
      end
      if (cmd.unknown) res_ok_r <= 1'b0;
      if (cmd.apply) begin
        res_ok_r <= have_r;
        if (have_r) begin
          valid_r[best_r] <= is_arm;
          cnt_r <= is_arm ? cnt_r + 1'b1 : cnt_r - 1'b1;
        end
      end
      if (cmd.push) pend_v_r <= 1'b0;
      if (cmd.fire) begin
        done_r[best_r] <= 1'b1;
        pend_v_r    <= 1'b1;
        pend_task_r <= rd_task_r;
        pend_kind_r <= drop ? dtq_pkg::KIND_DROPPED : dtq_pkg::KIND_FIRED;
        if (drop || !rearm) begin
          valid_r[best_r] <= 1'b0;
          cnt_r      <= cnt_r - 1'b1;
          pend_cnt_r <= cnt_r - 1'b1;
        end else begin
          pend_cnt_r <= cnt_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.push || cmd.final_out) begin
      out_valid <= 1'b1;
      if (cmd.push || pend_v_r) begin
        out_kind          <= pend_kind_r;
        out_task          <= pend_task_r;
        out_ok            <= 1'b1;
        out_pending_count <= dtq_pkg::CNT_OUT_W'(pend_cnt_r);
      end else begin
        out_kind          <= is_poll ? dtq_pkg::KIND_NONE : dtq_pkg::KIND_DONE;
        out_task          <= '0;
        out_ok            <= is_poll ? 1'b0 : res_ok_r;
        out_pending_count <= dtq_pkg::CNT_OUT_W'(cnt_r);
      end
      out_last <= cmd.final_out;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.scan_done = sdone_r;
  assign sts.found     = have_r;
  assign sts.is_poll   = is_poll;
  assign sts.known     = known;
  assign sts.pend_v    = pend_v_r;
  assign sts.out_free  = out_free;

  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CW'($countones(valid_r)))
    else $error("pending count out of step with valid bits");

  a_sweep_over: assert property (@(posedge clk) disable iff (!rst_n)
    sdone_r |-> !iss_r && !stg_v_r)
    else $error("sweep reported done while still reading");

  a_fire_due: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |-> have_r && valid_r[best_r] && (best_dl_r <= now_r))
    else $error("fired a slot that is not due");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push || cmd.final_out) |-> out_free)
    else $error("result register overwritten");

endmodule

/* rtl/core/deadline_timer_queue_core.sv */
// deadline_timer_queue_core: top level of the timer queue
// depends on dtq_pkg, dtq_ctrl and dtq_datapath
//
//  port group | direction | handshake         | carries
//  in_*       | in        | in_valid/in_stall | one command item
//  out_*      | out       | out_valid/out_stall | one result item
//  cfg_*      | in        | cfg_valid/cfg_ready | skip threshold
//
// each sweep reads every slot in turn through the read register into the compare stage;
// an arm or cancel takes one sweep, then an apply step, then its result
// a poll takes one sweep per due entry plus one final sweep and the closing result,
// each due entry adding a read and an update of the chosen slot and, after the first, a
// step to send the previous result
// the result register lets a new item in while the last result waits
// reset is synchronous, active low; it empties the table and sets threshold 1000
// a stalled output holds the sequencer only when it has a further result to send
module deadline_timer_queue_core #(
  parameter int SLOTS = dtq_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_opcode,
  input  logic [dtq_pkg::TIME_W-1:0]    in_now,
  input  logic [dtq_pkg::TIME_W-1:0]    in_time_value,
  input  logic [dtq_pkg::PER_W-1:0]     in_period,
  input  logic [dtq_pkg::ID_W-1:0]      in_task_id,
  input  logic [dtq_pkg::ID_W-1:0]      in_repeat_id,
  input  logic                          in_can_skip,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtq_pkg::THR_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [dtq_pkg::ID_W-1:0]      out_task,
  output logic                          out_ok,
  output logic [dtq_pkg::CNT_OUT_W-1:0] out_pending_count,
  output logic                          out_last
);

  dtq_pkg::cmd_t cmd;
  dtq_pkg::sts_t sts;

  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtq_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_opcode),
    .in_now            (in_now),
    .in_time_value     (in_time_value),
    .in_period         (in_period),
    .in_task_id        (in_task_id),
    .in_repeat_id      (in_repeat_id),
    .in_can_skip       (in_can_skip),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_task          (out_task),
    .out_ok            (out_ok),
    .out_pending_count (out_pending_count),
    .out_last          (out_last)
  );

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for deadline_timer_queue_core
// depends on dtq_pkg and the core; scoreboard class holds the timer table model
`timescale 1ns / 100ps

module testbench;

  localparam int NSLOT = 16;
  localparam int WDOG_LIMIT = 200000;
  // opcodes with no meaning
  localparam logic [2:0] OP_RSVD_LO = 3'd6;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  typedef struct {
    dtq_pkg::kind_t kind;
    logic [31:0]    task_id;
    logic           ok;
    logic [4:0]     pend;
    logic           last;
  } res_t;

  class timer_scoreboard;
    bit          valid[NSLOT];
    logic [47:0] dl[NSLOT];
    logic [31:0] per[NSLOT];
    logic [31:0] tsk[NSLOT];
    logic [31:0] rep[NSLOT];
    bit          skp[NSLOT];
    logic [31:0] thr;
    res_t        pending_q[$];
    int          errors;

    function new();
      foreach (valid[i]) valid[i] = 0;
      thr = dtq_pkg::THR_RESET;
      errors = 0;
    endfunction

    function int held();
      int c;
      c = 0;
      foreach (valid[i]) if (valid[i]) c++;
      return c;
    endfunction

    function logic [47:0] sadd(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

    function void push_res(dtq_pkg::kind_t k, logic [31:0] t, logic o, logic l);
      res_t r;
      r.kind = k; r.task_id = t; r.ok = o; r.pend = 5'(held()); r.last = l;
      pending_q.insert(pending_q.size(), r);
    endfunction

    function bit arm(logic [47:0] d, logic [31:0] p, logic [31:0] t,
                     logic [31:0] r, bit s);
      for (int i = 0; i < NSLOT; i++) begin
        if (!valid[i]) begin
          valid[i] = 1; dl[i] = d; per[i] = p; tsk[i] = t; rep[i] = r; skp[i] = s;
          return 1;
        end
      end
      return 0;
    endfunction

    function bit cancel(bit by_rep, logic [31:0] id);
      int best;
      best = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (valid[i] && (by_rep ? rep[i] : tsk[i]) == id)
          if (best < 0 || dl[i] < dl[best]) best = i;
      end
      if (best < 0) return 0;
      valid[best] = 0;
      return 1;
    endfunction

    function void note_item(logic [2:0] op, logic [47:0] now, logic [47:0] tv,
                            logic [31:0] p, logic [31:0] t, logic [31:0] r, bit s);
      bit ok;
      bit done[NSLOT];
      int n, best;
      dtq_pkg::kind_t k;
      logic [31:0] tt;
      ok = 0;
      case (op)
        dtq_pkg::OP_ARM_ABS:    ok = arm(tv, 32'd0, t, 32'd0, s);
        dtq_pkg::OP_ARM_DELAY:  ok = arm(sadd(now, tv), 32'd0, t, 32'd0, s);
        dtq_pkg::OP_ARM_PERIOD: ok = arm(sadd(now, {16'd0, p}), p, t, r, s);
        dtq_pkg::OP_CANCEL_TSK: ok = cancel(0, t);
        dtq_pkg::OP_CANCEL_REP: ok = cancel(1, r);
        dtq_pkg::OP_POLL: begin
          foreach (done[i]) done[i] = 0;
          n = 0;
          forever begin
            best = -1;
            for (int i = 0; i < NSLOT; i++)
              if (valid[i] && !done[i] && dl[i] <= now)
                if (best < 0 || dl[i] < dl[best]) best = i;
            if (best < 0) break;
            done[best] = 1;
            tt = tsk[best];
            k = dtq_pkg::KIND_FIRED;
            if (skp[best] && (now - dl[best]) > {16'd0, thr}) begin
              valid[best] = 0;
              k = dtq_pkg::KIND_DROPPED;
            end else if (per[best] != 0 && rep[best] != 0) begin
              dl[best] = sadd(now, {16'd0, per[best]});
            end else begin
              valid[best] = 0;
            end
            push_res(k, tt, 1, 0);
            n++;
          end
          if (n == 0) push_res(dtq_pkg::KIND_NONE, 32'd0, 0, 1);
          else pending_q[pending_q.size()-1].last = 1;
          return;
        end
        default: ok = 0;
      endcase
      push_res(dtq_pkg::KIND_DONE, 32'd0, ok, 1);
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: kind %0d task %0h", a.kind, a.task_id);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (a.kind !== e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, a.kind); errors++;
      end
      if (a.task_id !== e.task_id) begin
        $error("out_task: expected %0h actual %0h", e.task_id, a.task_id); errors++;
      end
      if (a.ok !== e.ok) begin
        $error("ok: expected %0b actual %0b", e.ok, a.ok); errors++;
      end
      if (a.pend !== e.pend) begin
        $error("pending_count: expected %0d actual %0d", e.pend, a.pend); errors++;
      end
      if (a.last !== e.last) begin
        $error("last: expected %0b actual %0b", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [2:0]  in_opcode;
  logic [47:0] in_now, in_time_value;
  logic [31:0] in_period, in_task_id, in_repeat_id;
  logic        in_can_skip;
  logic        cfg_valid, cfg_ready;
  logic [31:0] cfg_data;
  logic        out_valid, out_stall;
  logic [1:0]  out_kind;
  logic [31:0] out_task;
  logic        out_ok;
  logic [4:0]  out_pending_count;
  logic        out_last;

  timer_scoreboard sb;
  logic [47:0] cur_now;
  bit          no_idle;     // long stretch with no idling on either side
  bit          hold_off;    // receiver holding off
  int          idle_cycles;
  res_t        got;

  deadline_timer_queue_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_now(in_now), .in_time_value(in_time_value), .in_period(in_period),
    .in_task_id(in_task_id), .in_repeat_id(in_repeat_id), .in_can_skip(in_can_skip),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_task(out_task), .out_ok(out_ok), .out_pending_count(out_pending_count),
    .out_last(out_last)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stall, checks on accepted items
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.kind = dtq_pkg::kind_t'(out_kind); got.task_id = out_task; got.ok = out_ok;
        got.pend = out_pending_count; got.last = out_last;
        sb.check_result(got);
      end
      out_stall <= hold_off || (!no_idle && $urandom_range(99) < 19);
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // valid stays up after an accepted item until the next item or an idle cycle
  task automatic send(logic [2:0] op, logic [47:0] now, logic [47:0] tv,
                      logic [31:0] p, logic [31:0] t, logic [31:0] r, bit s);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_opcode <= op; in_now <= now; in_time_value <= tv;
    in_period <= p; in_task_id <= t; in_repeat_id <= r; in_can_skip <= s;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, now, tv, p, t, r, s);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_thr(logic [31:0] v);
    in_valid <= 0;
    drain();
    cfg_valid <= 1; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.thr = v;
  endtask

  // random command, mostly well-formed arm/poll traffic over a small id pool
  task automatic rand_item();
    int sel;
    logic [47:0] tv;
    sel = $urandom_range(99);
    cur_now = cur_now + 48'($urandom_range(0, 1500));
    tv = 48'({$urandom, $urandom});
    if ($urandom_range(9) != 0) tv = 48'($urandom_range(0, 3000));
    if (sel < 20)
      send(dtq_pkg::OP_ARM_ABS, cur_now, cur_now + tv - 48'd1500, 0, $urandom_range(8),
           $urandom, 1'($urandom_range(1)));
    else if (sel < 38)
      send(dtq_pkg::OP_ARM_DELAY, cur_now, tv, $urandom, $urandom_range(8), $urandom,
           1'($urandom_range(1)));
    else if (sel < 52)
      send(dtq_pkg::OP_ARM_PERIOD, cur_now, 48'($urandom),
           ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 2000),
           $urandom_range(8), $urandom_range(4), 1'($urandom_range(1)));
    else if (sel < 80)
      send(dtq_pkg::OP_POLL, cur_now, 48'($urandom), $urandom, $urandom, $urandom,
           1'($urandom_range(1)));
    else if (sel < 88)
      send(dtq_pkg::OP_CANCEL_TSK, cur_now, 0, 0, $urandom_range(8), 0, 0);
    else if (sel < 96)
      send(dtq_pkg::OP_CANCEL_REP, cur_now, 0, 0, 0, $urandom_range(4), 0);
    else
      send(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), 48'({$urandom, $urandom}),
           48'({$urandom, $urandom}), $urandom, $urandom, $urandom,
           1'($urandom_range(1)));
  endtask

  localparam logic [47:0] TM = {48{1'b1}};

  initial begin
    sb = new();
    rst_n = 0; in_valid = 0; in_opcode = 0; in_now = 0; in_time_value = 0;
    in_period = 0; in_task_id = 0; in_repeat_id = 0; in_can_skip = 0;
    cfg_valid = 0; cfg_data = 0; no_idle = 0; hold_off = 0; cur_now = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty poll, extremes, saturation, degenerate periodic, cancels, unknown opcodes, overfull table
    send(dtq_pkg::OP_POLL, 0, 0, 0, 0, 0, 0);
    send(dtq_pkg::OP_ARM_ABS, 0, TM, 0, 32'hFFFFFFFF, 0, 1);
    send(dtq_pkg::OP_ARM_DELAY, TM, TM, 0, 32'h1, 0, 0);
    send(dtq_pkg::OP_ARM_PERIOD, TM - 48'd5, 0, 32'hFFFFFFFF, 32'h2, 32'hFFFFFFFF, 0);
    send(dtq_pkg::OP_ARM_PERIOD, 10, 0, 0, 32'h3, 32'h7, 1);
    send(dtq_pkg::OP_ARM_PERIOD, 10, 0, 5, 32'h4, 0, 0);
    send(dtq_pkg::OP_ARM_ABS, 0, 0, 0, 32'h5, 0, 1);
    send(dtq_pkg::OP_POLL, 5000, 0, 0, 0, 0, 0);
    send(dtq_pkg::OP_POLL, TM, 0, 0, 0, 0, 0);
    send(dtq_pkg::OP_POLL, TM, 0, 0, 0, 0, 0);
    send(dtq_pkg::OP_CANCEL_TSK, 0, 0, 0, 32'h9, 0, 0);
    send(dtq_pkg::OP_CANCEL_REP, 0, 0, 0, 0, 32'hFFFFFFFF, 0);
    send(dtq_pkg::OP_CANCEL_REP, 0, 0, 0, 0, 0, 0);
    send(OP_RSVD_LO, TM, TM, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
    send(OP_RSVD_HI, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++)
      send(dtq_pkg::OP_ARM_ABS, 0, 48'(100 + i % 3), 0, i, 0, i[0]);
    write_thr(0);
    send(dtq_pkg::OP_POLL, 101, 0, 0, 0, 0, 0);
    send(dtq_pkg::OP_POLL, 48'h0000FFFFFFFF, 0, 0, 0, 0, 0);

    // random phases over several thresholds
    write_thr(32'hFFFFFFFF);
    for (int i = 0; i < 110; i++) rand_item();
    write_thr(500);
    // receiver holds off while the sender keeps offering items
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 40; i++) rand_item();
        in_valid <= 0;
      end
    join
    // sender pauses until all results are back
    drain();
    no_idle = 1;
    for (int i = 0; i < 100; i++) rand_item();
    no_idle = 0;
    write_thr($urandom);
    for (int i = 0; i < 110; i++) rand_item();
    write_thr(1000);
    for (int i = 0; i < 80; i++) rand_item();

    in_valid <= 0;
    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

/* sim.f */
rtl/core/dtq_pkg.sv
rtl/core/dtq_ctrl.sv
rtl/core/dtq_datapath.sv
rtl/core/deadline_timer_queue_core.sv
tb/testbench.sv
